// File: design/cpba_pkg.sv
package cpba_pkg;

    localparam int POOL_PAGES_DEF    = 4096;
    localparam int MAP_WORD_BITS_DEF = 32;

    localparam int ADDR_W       = 32;
    localparam int PAGE_SHIFT   = 12;
    localparam int PGN_W        = ADDR_W - PAGE_SHIFT;
    localparam int COUNT_W      = 13;
    localparam int START_PAGE_W = 12;
    localparam int STATUS_W     = 2;
    localparam int DATA_W       = 48;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h1000_0000;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREE_REJECT = 2'd2;

endpackage

// File: design/cpba_map_ram.sv
module cpba_map_ram
    import cpba_pkg::*;
#(
    parameter int DEPTH = POOL_PAGES_DEF / MAP_WORD_BITS_DEF,
    parameter int W     = MAP_WORD_BITS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: design/cpba_run_search.sv
module cpba_run_search
    import cpba_pkg::*;
#(
    parameter int W     = MAP_WORD_BITS_DEF,
    parameter int RUN_W = $clog2(POOL_PAGES_DEF + 1)
)
(
    input  logic [W-1:0]         free_vec,
    input  logic [RUN_W-1:0]     run_in,
    input  logic [COUNT_W-1:0]   count,
    output logic                 hit,
    output logic [$clog2(W)-1:0] hit_bit,
    output logic [RUN_W-1:0]     run_out
);

    localparam int ZW    = $clog2(W + 1);
    localparam int LEV   = $clog2(W);
    localparam int BIT_W = $clog2(W);
    localparam int CW    = ((RUN_W > COUNT_W) ? RUN_W : COUNT_W) + 1;

    // zp: one above the index of the last used bit at or below each position, 0 if none
    logic [ZW-1:0] zp [LEV+1][W];
    logic [CW-1:0] total [W];
    logic [W-1:0]  hit_vec;

    always_comb
    begin
        for (int e = 0; e < W; e++)
        begin
            zp[0][e] = free_vec[e] ? '0 : ZW'(e + 1);
        end
        for (int k = 0; k < LEV; k++)
        begin
            for (int e = 0; e < W; e++)
            begin
                if (e >= (1 << k) && zp[k][e - (1 << k)] > zp[k][e])
                begin
                    zp[k+1][e] = zp[k][e - (1 << k)];
                end
                else
                begin
                    zp[k+1][e] = zp[k][e];
                end
            end
        end
        for (int e = 0; e < W; e++)
        begin
            if (zp[LEV][e] == '0)
            begin
                total[e] = CW'(run_in) + CW'(e + 1);
            end
            else
            begin
                total[e] = CW'(e + 1) - CW'(zp[LEV][e]);
            end
            hit_vec[e] = (total[e] >= CW'(count));
        end
        hit     = |hit_vec;
        hit_bit = '0;
        for (int e = W - 1; e >= 0; e--)
        begin
            if (hit_vec[e])
            begin
                hit_bit = BIT_W'(e);
            end
        end
        if (zp[LEV][W-1] == '0)
        begin
            run_out = RUN_W'(CW'(run_in) + CW'(W));
        end
        else
        begin
            run_out = RUN_W'(CW'(W) - CW'(zp[LEV][W-1]));
        end
    end

endmodule

// File: design/contiguous_page_bitmap_allocator.sv
// channel   | ports                   | contents (low bit first)
// ----------+-------------------------+----------------------------------------------
// request   | s_axis_tvalid/tready    | tuser: req_type; tdata: free_address, page_count
// result    | m_axis_tvalid/tready    | tuser: status; tdata: start_page, start_address
// config    | cfg_we, cfg_wdata       | pool_base, bits 11..0 dropped
//
// after reset the used map is cleared one word per cycle (MAP_WORDS words, 128 by
// default) before the first request is taken.
// allocate: scan one map word per cycle from the map ram read port, then mark
// the run word by word and hand over the result.
// free: divide, split, clear each word; rejects and zero counts go to the result.
// one request in flight; a result waiting on m_axis_tready holds the next request in
// its last cycle.
module contiguous_page_bitmap_allocator
    import cpba_pkg::*;
#(
    parameter int POOL_PAGES    = POOL_PAGES_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,   // free_address, page_count
    input  logic                s_axis_tuser,   // req_type
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata,   // start_page, start_address
    output logic [STATUS_W-1:0] m_axis_tuser    // status
);

    localparam int W         = MAP_WORD_BITS;
    localparam int MAP_WORDS = (POOL_PAGES + W - 1) / W;
    localparam int LAST      = MAP_WORDS - 1;
    localparam int LAST_BITS = POOL_PAGES - LAST * W;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(W);
    localparam int NW        = $clog2(W + 1);
    localparam int PG_W      = $clog2(POOL_PAGES);
    localparam int RUN_W     = $clog2(POOL_PAGES + 1);
    localparam int SW        = ((PG_W > COUNT_W) ? PG_W : COUNT_W) + 1;
    localparam int MW        = ((RUN_W > COUNT_W) ? RUN_W : COUNT_W);
    localparam int END_W     = ((PGN_W > RUN_W) ? PGN_W : RUN_W) + 1;
    localparam int SHIFT     = PG_W + BIT_W;
    localparam int RW        = PG_W + 2;
    localparam int unsigned RECIP = ((1 << SHIFT) + W - 1) / W;
    localparam logic [W-1:0] LAST_MASK = {W{1'b1}} >> (W - LAST_BITS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_MARK  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    // control
    logic [2:0]       state_reg, state_next;
    logic [WA_W-1:0]  ra_reg, ra_next;
    logic             sv_reg, sv_next;
    logic             wb_v_reg, wb_v_next;
    logic             m_valid_reg, m_valid_next;
    logic [PGN_W-1:0] base_reg, base_next;

    // payload
    logic                kind_reg, kind_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [PG_W-1:0]     pg_reg, pg_next;
    logic [WA_W-1:0]     q_reg, q_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic [PG_W-1:0]     wp_reg, wp_next;
    logic [WA_W-1:0]     pw_reg, pw_next;
    logic [WA_W-1:0]     mk_word_reg, mk_word_next;
    logic [BIT_W-1:0]    mk_bit_reg, mk_bit_next;
    logic [COUNT_W-1:0]  mk_rem_reg, mk_rem_next;
    logic [WA_W-1:0]     wb_addr_reg, wb_addr_next;
    logic [W-1:0]        wb_mask_reg, wb_mask_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PG_W-1:0]     res_page_reg, res_page_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [START_PAGE_W-1:0] out_page_reg, out_page_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;

    // ram ports
    logic            ram_we;
    logic [WA_W-1:0] ram_waddr, ram_raddr;
    logic [W-1:0]    ram_wdata, ram_rdata;

    // search
    logic [W-1:0]     free_vec;
    logic             s_hit;
    logic [BIT_W-1:0] s_hit_bit;
    logic [RUN_W-1:0] s_run_out;

    // request decode
    logic [ADDR_W-1:0]  in_addr;
    logic [COUNT_W-1:0] in_cnt;
    logic               free_bad;
    logic [PG_W+RW-1:0] prod;
    logic [PG_W-1:0]    q_pages;
    logic [RUN_W-1:0]   pages_left;

    // marking
    logic [NW-1:0]    t1, avail, n_take;
    logic [BIT_W-1:0] lo;
    logic [W-1:0]     ones, mask;
    logic [COUNT_W-1:0] rem_after;
    logic             accept;

    assign in_addr = s_axis_tdata[ADDR_W-1:0];
    assign in_cnt  = s_axis_tdata[ADDR_W+COUNT_W-1:ADDR_W];
    assign accept  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(DATA_W - START_PAGE_W - ADDR_W){1'b0}}, out_addr_reg, out_page_reg};

    assign free_bad = (in_addr == '0) || (in_cnt == '0)
                   || (in_addr[PAGE_SHIFT-1:0] != '0)
                   || (in_addr[ADDR_W-1:PAGE_SHIFT] < base_reg)
                   || (END_W'(in_addr[ADDR_W-1:PAGE_SHIFT])
                       >= END_W'(base_reg) + END_W'(POOL_PAGES));

    assign free_vec = ~ram_rdata & ((pw_reg == WA_W'(LAST)) ? LAST_MASK : {W{1'b1}});

    // word index of a page by multiply with the reciprocal of the word size
    assign prod       = (PG_W+RW)'(pg_reg) * (PG_W+RW)'(RW'(RECIP));
    assign q_pages    = PG_W'(q_reg) * PG_W'(W);
    assign pages_left = RUN_W'(POOL_PAGES) - RUN_W'(pg_reg);

    // allocate marks downward from the hit word, free clears upward
    assign t1     = NW'(mk_bit_reg) + NW'(1);
    assign avail  = (kind_reg == REQ_ALLOC) ? t1 : NW'(W) - NW'(mk_bit_reg);
    assign n_take = (mk_rem_reg < COUNT_W'(avail)) ? NW'(mk_rem_reg) : avail;
    assign lo     = (kind_reg == REQ_ALLOC) ? BIT_W'(t1 - n_take) : mk_bit_reg;
    assign ones   = W'(((W+1)'(1) << n_take) - (W+1)'(1));
    assign mask   = ones << lo;
    assign rem_after = mk_rem_reg - COUNT_W'(n_take);

    cpba_run_search #(
        .W     (W),
        .RUN_W (RUN_W)
    ) u_search (
        .free_vec (free_vec),
        .run_in   (run_reg),
        .count    (cnt_reg),
        .hit      (s_hit),
        .hit_bit  (s_hit_bit),
        .run_out  (s_run_out)
    );

    cpba_map_ram #(
        .DEPTH (MAP_WORDS),
        .W     (W),
        .AW    (WA_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wb_addr_reg;
        ram_wdata = (kind_reg == REQ_ALLOC) ? (ram_rdata | wb_mask_reg)
                                            : (ram_rdata & ~wb_mask_reg);
        ram_raddr = ra_reg;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = ra_reg;
            ram_wdata = '0;
        end
        else if (wb_v_reg)
        begin
            ram_we = 1'b1;
        end
        if (state_reg == S_MARK)
        begin
            ram_raddr = mk_word_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ra_next         = ra_reg;
        sv_next         = 1'b0;
        wb_v_next       = 1'b0;
        m_valid_next    = m_valid_reg;
        base_next       = base_reg;
        kind_next       = kind_reg;
        cnt_next        = cnt_reg;
        pg_next         = pg_reg;
        q_next          = q_reg;
        run_next        = run_reg;
        wp_next         = wp_reg;
        pw_next         = pw_reg;
        mk_word_next    = mk_word_reg;
        mk_bit_next     = mk_bit_reg;
        mk_rem_next     = mk_rem_reg;
        wb_addr_next    = wb_addr_reg;
        wb_mask_next    = wb_mask_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_addr_next   = out_addr_reg;

        if (cfg_we)
        begin
            base_next = cfg_wdata[ADDR_W-1:PAGE_SHIFT];
        end
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                if (ra_reg == WA_W'(LAST))
                begin
                    ra_next    = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ra_next = ra_reg + WA_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = s_axis_tuser;
                    cnt_next        = in_cnt;
                    pg_next         = PG_W'(in_addr[ADDR_W-1:PAGE_SHIFT] - base_reg);
                    res_page_next   = '0;
                    res_status_next = ST_DONE;
                    ra_next         = '0;
                    run_next        = '0;
                    wp_next         = '0;
                    pw_next         = '0;
                    if (s_axis_tuser == REQ_ALLOC)
                    begin
                        if (in_cnt == '0)
                        begin
                            res_status_next = ST_ALLOC_FAIL;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (free_bad)
                    begin
                        res_status_next = ST_FREE_REJECT;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_SCAN:
            begin
                // reads run one word ahead of the search
                sv_next = 1'b1;
                if (ra_reg != WA_W'(LAST))
                begin
                    ra_next = ra_reg + WA_W'(1);
                end
                if (sv_reg)
                begin
                    if (s_hit)
                    begin
                        res_page_next = PG_W'(SW'(wp_reg) + SW'(s_hit_bit) + SW'(1)
                                              - SW'(cnt_reg));
                        mk_word_next  = pw_reg;
                        mk_bit_next   = s_hit_bit;
                        mk_rem_next   = cnt_reg;
                        ra_next       = '0;
                        state_next    = S_MARK;
                    end
                    else if (pw_reg == WA_W'(LAST))
                    begin
                        res_status_next = ST_ALLOC_FAIL;
                        ra_next         = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        run_next = s_run_out;
                        wp_next  = wp_reg + PG_W'(W);
                        pw_next  = pw_reg + WA_W'(1);
                    end
                end
            end
            S_DIV:
            begin
                q_next     = WA_W'(prod >> SHIFT);
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                mk_word_next = q_reg;
                mk_bit_next  = BIT_W'(pg_reg - q_pages);
                // pages past the pool end are dropped
                mk_rem_next  = (MW'(cnt_reg) < MW'(pages_left)) ? cnt_reg
                                                                : COUNT_W'(pages_left);
                state_next   = S_MARK;
            end
            S_MARK:
            begin
                wb_v_next    = 1'b1;
                wb_addr_next = mk_word_reg;
                wb_mask_next = mask;
                mk_rem_next  = rem_after;
                if (kind_reg == REQ_ALLOC)
                begin
                    mk_word_next = mk_word_reg - WA_W'(1);
                    mk_bit_next  = BIT_W'(W - 1);
                end
                else
                begin
                    mk_word_next = mk_word_reg + WA_W'(1);
                    mk_bit_next  = '0;
                end
                if (rem_after == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_page_next   = START_PAGE_W'(res_page_reg);
                    if (res_status_reg == ST_DONE && kind_reg == REQ_ALLOC)
                    begin
                        out_addr_next = {PGN_W'(base_reg + PGN_W'(res_page_reg)),
                                         {PAGE_SHIFT{1'b0}}};
                    end
                    else
                    begin
                        out_addr_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ra_reg      <= '0;
            sv_reg      <= 1'b0;
            wb_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            base_reg    <= BASE_RESET[ADDR_W-1:PAGE_SHIFT];
        end
        else
        begin
            state_reg   <= state_next;
            ra_reg      <= ra_next;
            sv_reg      <= sv_next;
            wb_v_reg    <= wb_v_next;
            m_valid_reg <= m_valid_next;
            base_reg    <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        cnt_reg        <= cnt_next;
        pg_reg         <= pg_next;
        q_reg          <= q_next;
        run_reg        <= run_next;
        wp_reg         <= wp_next;
        pw_reg         <= pw_next;
        mk_word_reg    <= mk_word_next;
        mk_bit_reg     <= mk_bit_next;
        mk_rem_reg     <= mk_rem_next;
        wb_addr_reg    <= wb_addr_next;
        wb_mask_reg    <= wb_mask_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
        out_addr_reg   <= out_addr_next;
    end

endmodule

// File: sim/allocator_checker.sv
`timescale 1ns / 100ps

module allocator_checker
    import cpba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_wdata,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,   // free_address, page_count
    input  logic                s_axis_tuser,   // req_type
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [DATA_W-1:0]   m_axis_tdata,   // start_page, start_address
    input  logic [STATUS_W-1:0] m_axis_tuser,   // status
    output int                  mismatches,
    output int                  pending
);

    localparam int POOL_PAGES = POOL_PAGES_DEF;
    localparam int PRINT_MAX  = 50;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [START_PAGE_W-1:0] start_page;
        logic [ADDR_W-1:0]       start_address;
    } grant_t;

    bit [POOL_PAGES-1:0] page_busy;
    logic [ADDR_W-1:0]   pool_base;
    grant_t              expected_grants[$];

    task automatic report_error(input string msg);
        if (mismatches < PRINT_MAX)
            $display("%0t: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    // first-fit search over the used map, or clearing a run on free
    task automatic predict_grant(input logic kind, input logic [ADDR_W-1:0] addr,
                                 input logic [COUNT_W-1:0] count, output grant_t res);
        int run;
        int first;
        int pg;
        int idx;
        bit found;
        logic [ADDR_W+1:0] pool_end;
        res = '0;
        res.status = ST_DONE;
        if (kind == REQ_ALLOC)
        begin
            run = 0;
            first = 0;
            found = 1'b0;
            if (count != 0)
            begin
                for (idx = 0; idx < POOL_PAGES && !found; idx++)
                begin
                    if (page_busy[idx])
                        run = 0;
                    else
                    begin
                        if (run == 0)
                            first = idx;
                        run++;
                        if (run == int'(count))
                            found = 1'b1;
                    end
                end
            end
            if (found)
            begin
                for (idx = 0; idx < int'(count); idx++)
                    page_busy[first + idx] = 1'b1;
                res.start_page = first[START_PAGE_W-1:0];
                res.start_address = pool_base + (ADDR_W'(first) << PAGE_SHIFT);
            end
            else
                res.status = ST_ALLOC_FAIL;
        end
        else
        begin
            // end of pool is computed without wrapping
            pool_end = {2'b00, pool_base} + ((ADDR_W+2)'(POOL_PAGES) << PAGE_SHIFT);
            if (addr == '0 || count == '0 || addr[PAGE_SHIFT-1:0] != '0 ||
                addr < pool_base || {2'b00, addr} >= pool_end)
                res.status = ST_FREE_REJECT;
            else
            begin
                pg = int'((addr - pool_base) >> PAGE_SHIFT);
                for (idx = 0; idx < int'(count); idx++)
                    if (pg + idx < POOL_PAGES)
                        page_busy[pg + idx] = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t got;
        if (!rst_n)
        begin
            page_busy = '0;
            pool_base = BASE_RESET;
            expected_grants.delete();
            pending = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                pool_base = {cfg_wdata[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_grant(s_axis_tuser, s_axis_tdata[ADDR_W-1:0],
                              s_axis_tdata[ADDR_W +: COUNT_W], want);
                expected_grants.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tuser;
                got.start_page = m_axis_tdata[START_PAGE_W-1:0];
                got.start_address = m_axis_tdata[START_PAGE_W +: ADDR_W];
                if (expected_grants.size() == 0)
                    report_error($sformatf("result word with nothing expected: %0h",
                                           got));
                else
                begin
                    want = expected_grants.pop_front();
                    if (got.status != want.status)
                        report_error($sformatf("status: expected %0d got %0d",
                                               want.status, got.status));
                    if (got.start_page != want.start_page)
                        report_error($sformatf("start_page: expected %0d got %0d",
                                               want.start_page, got.start_page));
                    if (got.start_address != want.start_address)
                        report_error($sformatf("start_address: expected %08h got %08h",
                                               want.start_address, got.start_address));
                end
            end
            pending = expected_grants.size();
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cpba_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PAGES       = POOL_PAGES_DEF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [ADDR_W-1:0]   cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;     // free_address, page_count
    logic                s_axis_tuser = 1'b0;   // req_type
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;          // start_page, start_address
    logic [STATUS_W-1:0] m_axis_tuser;          // status

    int                  mismatches;
    int                  pending;
    int                  cycle_count = 0;
    int                  burst_left = 4;
    int                  stall_mode = 0;
    int                  mode_left = 0;
    int                  hold_left = 0;
    logic [ADDR_W-1:0]   pool_base_now = BASE_RESET;

    contiguous_page_bitmap_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    allocator_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL contiguous_page_bitmap_allocator");
            $finish;
        end
    end

    // result side backpressure: always ready, random, periodic, or long holds
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
        end
        else
            mode_left = mode_left - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= (cycle_count % 5 < 2);
            default:
            begin
                if (hold_left > 0)
                begin
                    hold_left = hold_left - 1;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        hold_left = $urandom_range(1, 25);
                end
            end
        endcase
    end

    // called right after a rising edge; returns after acceptance and any gap
    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr,
                                input logic [COUNT_W-1:0] count);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {{(DATA_W-ADDR_W-COUNT_W){1'b0}}, count, addr};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        if (burst_left > 0)
            burst_left = burst_left - 1;
        else
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_pool_base(input logic [ADDR_W-1:0] value);
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        pool_base_now = {value[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    endtask

    function automatic logic [ADDR_W-1:0] page_addr(input int page);
        return pool_base_now + (ADDR_W'(page) << PAGE_SHIFT);
    endfunction

    // mostly small allocations and well-formed frees, some big runs and junk
    task automatic send_random_requests(input int n);
        int pick;
        int page;
        logic [COUNT_W-1:0] count;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    count = COUNT_W'($urandom_range(1, 32));
                else if (pick < 96)
                    count = COUNT_W'($urandom_range(33, 300));
                else if (pick < 99)
                    count = COUNT_W'($urandom_range(0, PAGES));
                else
                    count = COUNT_W'($urandom_range(PAGES + 1, 8191));
                send_request(REQ_ALLOC, $urandom, count);
            end
            else if (pick < 85)
            begin
                page = $urandom_range(0, PAGES - 1);
                if ($urandom_range(0, 9) == 0)
                    page = $urandom_range(PAGES - 16, PAGES - 1);
                count = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom_range(1, 8191))
                                                     : COUNT_W'($urandom_range(1, 64));
                send_request(REQ_FREE, page_addr(page), count);
            end
            else
                send_request(1'($urandom_range(0, 1)), $urandom,
                             COUNT_W'($urandom_range(0, 8191)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset base
        send_request(REQ_ALLOC, 32'h0, 13'd0);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 13'd1);
        send_request(REQ_ALLOC, 32'h0, 13'd4096);
        send_request(REQ_ALLOC, 32'h0, 13'd8191);
        send_request(REQ_FREE, 32'h0, 13'd1);
        send_request(REQ_FREE, 32'h1000_0001, 13'd1);
        send_request(REQ_FREE, 32'h0FFF_F000, 13'd1);
        send_request(REQ_FREE, 32'h1100_0000, 13'd1);
        send_request(REQ_FREE, 32'h1000_0000, 13'd0);
        send_request(REQ_FREE, 32'h1000_0000, 13'd1);
        send_request(REQ_FREE, 32'h1000_0000, 13'd1);
        send_request(REQ_ALLOC, 32'h0, 13'd4096);
        send_request(REQ_ALLOC, 32'h0, 13'd1);
        // free past the end of the pool only clears the last page
        send_request(REQ_FREE, 32'h10FF_F000, 13'd8191);
        send_request(REQ_ALLOC, 32'h0, 13'd1);
        send_request(REQ_FREE, 32'h1000_0000, 13'd4096);
        send_request(REQ_ALLOC, 32'h0, 13'd5);
        send_request(REQ_ALLOC, 32'h0, 13'd3);
        send_request(REQ_FREE, 32'h1000_0000, 13'd5);
        send_request(REQ_ALLOC, 32'h0, 13'd6);
        send_request(REQ_ALLOC, 32'h0, 13'd4);
        send_request(REQ_FREE, 32'h1000_0000, 13'd4096);
        send_random_requests(170);

        // top of the address space: start addresses wrap past zero
        set_pool_base(32'hFFFF_F000);
        send_request(REQ_ALLOC, 32'h0, 13'd2);
        send_request(REQ_ALLOC, 32'h0, 13'd1);
        send_request(REQ_FREE, 32'h0000_1000, 13'd1);
        send_request(REQ_FREE, 32'hFFFF_FFFF, 13'd1);
        send_request(REQ_FREE, 32'hFFFF_F000, 13'd3);
        send_random_requests(170);

        // low bits of the written value are dropped, so this is base zero
        set_pool_base(32'h0000_0FFF);
        send_request(REQ_FREE, 32'h0, 13'd4);
        send_random_requests(170);

        set_pool_base(32'h1234_5ABC);
        send_random_requests(160);

        set_pool_base($urandom);
        send_random_requests(160);

        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS contiguous_page_bitmap_allocator");
        else
            $display("FAIL contiguous_page_bitmap_allocator");
        $finish;
    end

endmodule

// File: filelist.f
design/cpba_pkg.sv
design/cpba_map_ram.sv
design/cpba_run_search.sv
design/contiguous_page_bitmap_allocator.sv
sim/allocator_checker.sv
sim/testbench.sv
